// ===== hw/rtl/rvx_pkg.sv =====
// Shared constants and types for the RV32 subset execute unit.
package rvx_pkg;

  // Register file size and configuration reset
  localparam int unsigned    RegCountDefault = 32;
  localparam logic [31:0]    EndAddressReset = 32'h0000_1000;

  // Major opcodes
  localparam logic [6:0] OpLui    = 7'b0110111;
  localparam logic [6:0] OpAuipc  = 7'b0010111;
  localparam logic [6:0] OpJal    = 7'b1101111;
  localparam logic [6:0] OpJalr   = 7'b1100111;
  localparam logic [6:0] OpAluImm = 7'b0010011;
  localparam logic [6:0] OpAluReg = 7'b0110011;

  // Function codes
  localparam logic [2:0] F3Add = 3'b000;
  localparam logic [6:0] F7Add = 7'b0000000;
  localparam logic [6:0] F7Sub = 7'b0100000;

  // Upper immediate mask
  localparam logic [31:0] UpperMask = 32'hFFFF_F000;

  typedef logic [31:0] word_t;
  typedef logic [4:0]  reg_idx_t;

  // Last register write, used to bypass the register file read
  typedef struct packed {
    logic     valid;
    reg_idx_t index;
    word_t    value;
  } fwd_t;

  // Sign-extended I-type immediate
  function automatic word_t imm_i(input word_t w);
    return {{20{w[31]}}, w[31:20]};
  endfunction

  // Sign-extended J-type immediate
  function automatic word_t imm_j(input word_t w);
    return {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
  endfunction

endpackage

// ===== hw/rtl/rvx_if.sv =====
// Handshake interfaces for the instruction channel and the result channel.
interface rvx_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction;

  modport source (output valid, output instruction, input ready);
  modport sink   (input valid, input instruction, output ready);
endinterface

interface rvx_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_pc;
  logic        write_enable;
  logic [4:0]  write_index;
  logic [31:0] write_value;
  logic        unsupported;
  logic        stop;

  modport source (output valid, output next_pc, output write_enable, output write_index,
                  output write_value, output unsupported, output stop, input ready);
  modport sink   (input valid, input next_pc, input write_enable, input write_index,
                  input write_value, input unsupported, input stop, output ready);
endinterface

// ===== hw/rtl/rvx_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rvx_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/rv32_subset_execute_unit.sv =====
// Top level of the RV32 subset execute unit (LUI, AUIPC, JAL, JALR, ADDI, ADD, SUB).
//
// Executes one RISC-V instruction per beat on req, the word fetched at the pc that the
// previous result reported (zero after reset), and returns one result beat on rsp with
// the next pc, the register write, an unsupported flag and a stop flag (next pc at or
// beyond end_address, written through cfg_write/cfg_data). Throughput is one instruction
// per clock unless rsp stalls; after acceptance, rsp valid comes from the output register:
// the source operands are read from two register file RAMs at acceptance, the instruction
// executes in the following cycle and its result lands in the output register. A bypass
// from the last write covers back-to-back dependencies. The register file reads as zero
// after reset through per-entry valid bits, so there is no clearing pass. Unsupported
// encodings write nothing and step the pc by 4; the stop flag does not halt execution.
module rv32_subset_execute_unit #(
  parameter int unsigned RegCount = rvx_pkg::RegCountDefault
) (
  input  logic        clk,
  input  logic        rst,
  rvx_req_if.sink     req,
  rvx_rsp_if.source   rsp,
  input  logic        cfg_write,
  input  logic [31:0] cfg_data
);

  localparam int unsigned IdxW = $clog2(RegCount);

  // Pipeline control
  logic              s1_valid;
  logic              accept;
  logic              advance;

  // Execute stage registers
  rvx_pkg::word_t    s1_instr;
  rvx_pkg::word_t    pc;
  rvx_pkg::word_t    end_address;
  logic [RegCount-1:0] reg_valid;
  rvx_pkg::fwd_t     fwd;

  // Register file read data
  rvx_pkg::word_t    rd1_q;
  rvx_pkg::word_t    rd2_q;

  // Decode and execute
  logic [6:0]        opcode;
  rvx_pkg::reg_idx_t rd;
  logic [2:0]        funct3;
  rvx_pkg::reg_idx_t rs1;
  rvx_pkg::reg_idx_t rs2;
  logic [6:0]        funct7;
  rvx_pkg::word_t    opa;
  rvx_pkg::word_t    opb;
  rvx_pkg::word_t    pc_plus4;
  rvx_pkg::word_t    pc_next;
  rvx_pkg::word_t    result;
  logic              writes;
  logic              unsup;
  logic              wr_en;

  assign accept  = req.valid && req.ready;
  assign advance = s1_valid && (!rsp.valid || rsp.ready);
  assign req.ready = !s1_valid || advance;

  // Register file: one RAM per source port, both written alike
  rvx_ram #(.Width(32), .Depth(RegCount)) u_rf_a (
    .clk   (clk),
    .we    (wr_en),
    .waddr (rd[IdxW-1:0]),
    .wdata (result),
    .re    (accept),
    .raddr (req.instruction[15 +: IdxW]),
    .rdata (rd1_q)
  );

  rvx_ram #(.Width(32), .Depth(RegCount)) u_rf_b (
    .clk   (clk),
    .we    (wr_en),
    .waddr (rd[IdxW-1:0]),
    .wdata (result),
    .re    (accept),
    .raddr (req.instruction[20 +: IdxW]),
    .rdata (rd2_q)
  );

  // Split the instruction fields
  assign opcode = s1_instr[6:0];
  assign rd     = s1_instr[11:7];
  assign funct3 = s1_instr[14:12];
  assign rs1    = s1_instr[19:15];
  assign rs2    = s1_instr[24:20];
  assign funct7 = s1_instr[31:25];

  // Source operands: zero for x0 and out-of-range indexes, bypass the last write
  always_comb begin
    opa = '0;
    if (rs1 != '0 && int'(rs1) < int'(RegCount)) begin
      if (fwd.valid && fwd.index == rs1) begin
        opa = fwd.value;
      end else if (reg_valid[rs1[IdxW-1:0]]) begin
        opa = rd1_q;
      end
    end
  end

  always_comb begin
    opb = '0;
    if (rs2 != '0 && int'(rs2) < int'(RegCount)) begin
      if (fwd.valid && fwd.index == rs2) begin
        opb = fwd.value;
      end else if (reg_valid[rs2[IdxW-1:0]]) begin
        opb = rd2_q;
      end
    end
  end

  // Execute
  assign pc_plus4 = pc + 32'd4;

  always_comb begin
    pc_next = pc_plus4;
    result  = '0;
    writes  = 1'b0;
    unsup   = 1'b0;
    unique case (opcode)
      rvx_pkg::OpLui: begin
        result = s1_instr & rvx_pkg::UpperMask;
        writes = 1'b1;
      end
      rvx_pkg::OpAuipc: begin
        result = pc + (s1_instr & rvx_pkg::UpperMask);
        writes = 1'b1;
      end
      rvx_pkg::OpJal: begin
        result  = pc_plus4;
        pc_next = pc + rvx_pkg::imm_j(s1_instr);
        writes  = 1'b1;
      end
      rvx_pkg::OpJalr: begin
        if (funct3 == rvx_pkg::F3Add) begin
          result  = pc_plus4;
          pc_next = (opa + rvx_pkg::imm_i(s1_instr)) & ~32'd1;
          writes  = 1'b1;
        end else begin
          unsup = 1'b1;
        end
      end
      rvx_pkg::OpAluImm: begin
        if (funct3 == rvx_pkg::F3Add) begin
          result = opa + rvx_pkg::imm_i(s1_instr);
          writes = 1'b1;
        end else begin
          unsup = 1'b1;
        end
      end
      rvx_pkg::OpAluReg: begin
        if (funct3 == rvx_pkg::F3Add && funct7 == rvx_pkg::F7Add) begin
          result = opa + opb;
          writes = 1'b1;
        end else if (funct3 == rvx_pkg::F3Add && funct7 == rvx_pkg::F7Sub) begin
          result = opa - opb;
          writes = 1'b1;
        end else begin
          unsup = 1'b1;
        end
      end
      default: begin
        unsup = 1'b1;
      end
    endcase
  end

  // Drop writes to x0 and to registers beyond the file
  assign wr_en = advance && writes && rd != '0 && int'(rd) < int'(RegCount);

  // Control state: stage valid, pc, configuration, valid bits, bypass, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      pc          <= '0;
      end_address <= rvx_pkg::EndAddressReset;
      reg_valid   <= '0;
      fwd.valid   <= 1'b0;
      rsp.valid   <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (cfg_write) begin
        end_address <= cfg_data;
      end
      if (advance) begin
        pc        <= pc_next;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      if (wr_en) begin
        reg_valid[rd[IdxW-1:0]] <= 1'b1;
        fwd.valid               <= 1'b1;
        fwd.index               <= rd;
        fwd.value               <= result;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_instr <= req.instruction;
    end
    if (advance) begin
      rsp.next_pc      <= pc_next;
      rsp.write_enable <= wr_en;
      rsp.write_index  <= wr_en ? rd : '0;
      rsp.write_value  <= wr_en ? result : '0;
      rsp.unsupported  <= unsup;
      rsp.stop         <= (pc_next >= end_address);
    end
  end

  // Checks
  a_no_x0_write: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.write_enable |-> rsp.write_index != '0)
    else $error("write reported to x0");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.write_enable |-> int'(rsp.write_index) < int'(RegCount))
    else $error("write reported beyond register file");

  a_unsup_no_write: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.unsupported |-> !rsp.write_enable)
    else $error("unsupported instruction wrote a register");

  a_advance_shows: assert property (@(posedge clk) disable iff (rst)
    advance |=> rsp.valid && rsp.next_pc == pc)
    else $error("executed instruction missing from output or pc out of step");

endmodule
